[hw/rtl/pisc_pkg.sv]
// shared constants, register codes and types of the soft-start pi speed controller
`timescale 1ns / 1ps

package pisc_pkg;

  // field widths
  localparam int unsigned SETPOINT_W = 16;
  localparam int unsigned GAIN_W     = 32;
  localparam int unsigned RAMP_W     = 17;
  localparam int unsigned LIMIT_W    = 7;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned DUTY_W     = 23;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // shared multiplier operand widths
  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 20;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // register reset values
  localparam logic [SETPOINT_W-1:0] SETPOINT_RST  = 16'd100;
  localparam logic [GAIN_W-1:0]     SPT_RST       = 32'd65536;
  localparam logic [GAIN_W-1:0]     KP_RST        = 32'd65536;
  localparam logic [GAIN_W-1:0]     KI_RST        = 32'd65536;
  localparam logic [RAMP_W-1:0]     RAMP_STEP_RST = 17'd655;
  localparam logic [LIMIT_W-1:0]    DUTY_LIM_RST  = 7'd80;

  // 1.0 in q1.16
  localparam logic [RAMP_W-1:0] ONE_Q16 = 17'h10000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPT       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KP        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KI        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIM  = 3'd5;

  // operands for the shared multiplier
  typedef struct packed {
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } pisc_mul_req_t;

endpackage

[hw/rtl/pisc_mul.sv]
// shared unsigned 32x20 multiplier with registered product
`timescale 1ns / 1ps

module pisc_mul (
  input  logic                           clk,
  input  pisc_pkg::pisc_mul_req_t        req,
  output logic [pisc_pkg::MUL_P_W-1:0]   prod_r
);
  import pisc_pkg::*;

  logic [MUL_P_W-1:0] prod_nxt;

  // one product per cycle, result registered and ready in the next cycle
  always_comb begin
    prod_nxt = {{MUL_B_W{1'b0}}, req.a} * {{MUL_A_W{1'b0}}, req.b};
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

[hw/rtl/pi_speed_controller_soft_start_unit.sv]
// top level of the soft-start pi wheel speed controller
// Usage:
//   Input channel (in_valid / in_stall / in_tick_count): one signed encoder tick
//   count per control period. Result channel (out_valid / out_stall / out_duty,
//   out_tick_echo): one clamped q7.16 duty value per request, with the tick count
//   returned alongside. Configuration channel (cfg_valid / cfg_ready / cfg_index /
//   cfg_data): cfg_ready is always high; indexes above five are dropped.
//   The block takes no new request while one is being worked on: a sequencer
//   walks six passes through one shared 32x20 multiplier (speed, target, two for
//   the integral gain, two for the proportional gain) plus error, integral and
//   clamp steps.
//   in_stall is high while a request is being worked on.
//   When out_stall holds a result, the final step waits and the block keeps its
//   state until the result register is free; a new request may be taken while a
//   finished result is still waiting.
//   Reset (rst_n low, synchronous) restores the register defaults and clears the
//   ramp factor, integral sum and previous error.
`timescale 1ns / 1ps

module pi_speed_controller_soft_start_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [pisc_pkg::TICK_W-1:0]   in_tick_count,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [pisc_pkg::DUTY_W-1:0]          out_duty,
  output logic signed [pisc_pkg::TICK_W-1:0]   out_tick_echo,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pisc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pisc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import pisc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SPD, S_TGT, S_ERR, S_KIH, S_KIF, S_KPH, S_KPF, S_DUTY
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [SETPOINT_W-1:0] setpoint_r;
  logic [GAIN_W-1:0]     spt_r, kp_r, ki_r;
  logic [RAMP_W-1:0]     ramp_step_r;
  logic [LIMIT_W-1:0]    duty_lim_r;

  // controller state
  logic [RAMP_W-1:0]     ramp_r, ramp_nxt;
  logic signed [47:0]    int_sum_r;
  logic [39:0]           prev_mag_r;
  logic                  prev_neg_r;

  // working registers
  logic signed [TICK_W-1:0] tick_r;
  logic [16:0]           mag_r, mag_nxt;
  logic [47:0]           speed_r;
  logic signed [39:0]    err_r, err_nxt;
  logic [39:0]           err_mag_r, err_mag_nxt;
  logic                  err_neg_r;
  logic [MUL_P_W-1:0]    acc_r;
  logic [55:0]           gmag_r, gmag_nxt;
  logic signed [47:0]    integ_r, integ_nxt;

  // result register
  logic                  out_valid_r;
  logic [DUTY_W-1:0]     duty_r, duty_nxt;
  logic signed [TICK_W-1:0] echo_r;

  pisc_mul_req_t         mul_req;
  logic [MUL_P_W-1:0]    prod;

  logic                  in_take;
  logic                  out_free;
  logic [17:0]           ramp_sum;
  logic signed [49:0]    diff;
  logic [71:0]           acc_sum;
  logic signed [57:0]    int_wide, u_wide;
  logic [DUTY_W-1:0]     lim;
  logic signed [TICK_W:0] tick_ext;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_duty      = duty_r;
  assign out_tick_echo = echo_r;

  pisc_mul u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (prod)
  );

  // multiplier operand select per step
  always_comb begin
    mul_req = '0;
    case (state_r)
      S_SPD: begin
        mul_req.a = spt_r;
        mul_req.b = {3'b0, mag_r};
      end
      S_TGT: begin
        mul_req.a = {16'b0, setpoint_r};
        mul_req.b = {3'b0, ramp_r};
      end
      S_ERR: begin
        mul_req.a = ki_r;
        mul_req.b = prev_mag_r[19:0];
      end
      S_KIH: begin
        mul_req.a = ki_r;
        mul_req.b = prev_mag_r[39:20];
      end
      S_KIF: begin
        mul_req.a = kp_r;
        mul_req.b = err_mag_r[19:0];
      end
      S_KPH: begin
        mul_req.a = kp_r;
        mul_req.b = err_mag_r[39:20];
      end
      default: mul_req = '0;
    endcase
  end

  // tick magnitude and ramp update at request time
  always_comb begin
    tick_ext = {in_tick_count[TICK_W-1], in_tick_count};
    mag_nxt  = in_tick_count[TICK_W-1] ? 17'(-tick_ext) : 17'(tick_ext);
    ramp_sum = {1'b0, ramp_r} + {1'b0, ramp_step_r};
    ramp_nxt = (ramp_sum > {1'b0, ONE_Q16}) ? ONE_Q16 : ramp_sum[RAMP_W-1:0];
  end

  // error with 40 bit saturation, and its magnitude
  always_comb begin
    diff = $signed({17'b0, prod[32:0]}) - $signed({2'b0, speed_r});
    if ((&diff[49:39]) || !(|diff[49:39])) begin
      err_nxt = diff[39:0];
    end else if (diff[49]) begin
      err_nxt = {1'b1, 39'b0};
    end else begin
      err_nxt = {1'b0, {39{1'b1}}};
    end
    err_mag_nxt = err_r[39] ? 40'(-err_r) : 40'(err_r);
  end

  // two partial products joined, q16.16 floor
  always_comb begin
    acc_sum  = {20'b0, acc_r} + {prod, 20'b0};
    gmag_nxt = acc_sum[71:16];
  end

  // integral update with 48 bit saturation
  always_comb begin
    if (prev_neg_r) begin
      int_wide = $signed({{10{int_sum_r[47]}}, int_sum_r}) - $signed({2'b0, gmag_r});
    end else begin
      int_wide = $signed({{10{int_sum_r[47]}}, int_sum_r}) + $signed({2'b0, gmag_r});
    end
    if ((&int_wide[57:47]) || !(|int_wide[57:47])) begin
      integ_nxt = int_wide[47:0];
    end else if (int_wide[57]) begin
      integ_nxt = {1'b1, 47'b0};
    end else begin
      integ_nxt = {1'b0, {47{1'b1}}};
    end
  end

  // drive sum and clamp
  always_comb begin
    lim = {duty_lim_r, 16'b0};
    if (err_neg_r) begin
      u_wide = $signed({{10{integ_r[47]}}, integ_r}) - $signed({2'b0, gmag_r});
    end else begin
      u_wide = $signed({{10{integ_r[47]}}, integ_r}) + $signed({2'b0, gmag_r});
    end
    if (!u_wide[57] && (u_wide >= $signed({35'b0, lim}))) begin
      duty_nxt = lim;
    end else if (u_wide[57]) begin
      duty_nxt = '0;
    end else begin
      duty_nxt = u_wide[DUTY_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_take) state_nxt = S_SPD;
      S_SPD:   state_nxt = S_TGT;
      S_TGT:   state_nxt = S_ERR;
      S_ERR:   state_nxt = S_KIH;
      S_KIH:   state_nxt = S_KIF;
      S_KIF:   state_nxt = S_KPH;
      S_KPH:   state_nxt = S_KPF;
      S_KPF:   state_nxt = S_DUTY;
      S_DUTY:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state, control and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      setpoint_r  <= SETPOINT_RST;
      spt_r       <= SPT_RST;
      kp_r        <= KP_RST;
      ki_r        <= KI_RST;
      ramp_step_r <= RAMP_STEP_RST;
      duty_lim_r  <= DUTY_LIM_RST;
      ramp_r      <= '0;
      int_sum_r   <= '0;
      prev_mag_r  <= '0;
      prev_neg_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // configuration writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SETPOINT:  setpoint_r  <= cfg_data[SETPOINT_W-1:0];
          REG_SPT:       spt_r       <= cfg_data[GAIN_W-1:0];
          REG_KP:        kp_r        <= cfg_data[GAIN_W-1:0];
          REG_KI:        ki_r        <= cfg_data[GAIN_W-1:0];
          REG_RAMP_STEP: ramp_step_r <= cfg_data[RAMP_W-1:0];
          REG_DUTY_LIM:  duty_lim_r  <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (in_take) begin
        ramp_r <= ramp_nxt;
      end

      // result hand-off and state commit
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_DUTY && out_free) begin
        out_valid_r <= 1'b1;
        int_sum_r   <= integ_r;
        prev_mag_r  <= err_mag_r;
        prev_neg_r  <= err_neg_r;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      tick_r <= in_tick_count;
      mag_r  <= mag_nxt;
    end
    case (state_r)
      S_TGT: speed_r <= prod[47:0];
      S_ERR: err_r   <= err_nxt;
      S_KIH: begin
        acc_r     <= prod;
        err_mag_r <= err_mag_nxt;
        err_neg_r <= err_r[39];
      end
      S_KIF: gmag_r <= gmag_nxt;
      S_KPH: begin
        integ_r <= integ_nxt;
        acc_r   <= prod;
      end
      S_KPF: gmag_r <= gmag_nxt;
      S_DUTY: begin
        if (out_free) begin
          duty_r <= duty_nxt;
          echo_r <= tick_r;
        end
      end
      default: ;
    endcase
  end

  // checks
  a_ramp_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    ramp_r <= ONE_Q16)
    else $error("ramp factor above one");

  a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r == S_SPD)
    else $error("request taken but sequencer did not start");

  a_out_from_duty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DUTY)
    else $error("result raised outside the final step");

  a_err_mag: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_KIF |-> err_mag_r == (err_r[39] ? 40'(-err_r) : 40'(err_r)))
    else $error("error magnitude does not match error");

  a_duty_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUTY && out_valid_r && out_stall) |=> state_r == S_DUTY)
    else $error("final step left while result register busy");

endmodule
